### src/csl_pkg.sv
// Shared types, constants and lookup functions for the C subset lexer.
// No dependencies.
`default_nettype none
package csl_pkg;

	localparam int KW_MAX_LEN = 8;
	localparam int WIDX_W     = $clog2(KW_MAX_LEN);

	localparam logic [6:0] K_IDENT   = 7'd0;
	localparam logic [6:0] K_INT     = 7'd33;
	localparam logic [6:0] K_UINT    = 7'd34;
	localparam logic [6:0] K_LONG    = 7'd35;
	localparam logic [6:0] K_ULONG   = 7'd36;
	localparam logic [6:0] K_FLOAT   = 7'd37;
	localparam logic [6:0] K_DOUBLE  = 7'd38;
	localparam logic [6:0] K_LDOUBLE = 7'd39;
	localparam logic [6:0] K_CHAR    = 7'd40;
	localparam logic [6:0] K_STRING  = 7'd41;
	localparam logic [6:0] K_PUNCT0  = 7'd61;
	localparam logic [6:0] K_ERROR   = 7'd69;
	localparam logic [6:0] K_END     = 7'd70;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_EXP, M_SUF_U, M_SUF_L, M_OP,
		M_CHR0, M_CHRB, M_CHRO, M_STR
	} mode_t;

	typedef logic [KW_MAX_LEN-1:0][7:0] word_t;

	typedef struct packed {
		logic [6:0]  kind;
		logic [15:0] line;
		logic [7:0]  len;
		logic        last;
	} res_t;

	// results of one lexed byte, up to two beats
	typedef struct packed {
		logic push0;
		logic push1;
		res_t r0;
		res_t r1;
	} push_t;

	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [32] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof", "static",
		"struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
	};
	localparam int KW_LEN [32] = '{4, 5, 4, 4, 5, 8, 7, 2, 6, 4, 4, 6, 5, 3, 4, 2,
		3, 4, 8, 6, 5, 6, 6, 6, 6, 6, 7, 5, 8, 4, 8, 5};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// operator lead character: hit flag and table index
	function automatic logic [4:0] op_find(input logic [7:0] c);
		case (c)
			"+": return {1'b1, 4'd0};
			"-": return {1'b1, 4'd1};
			"*": return {1'b1, 4'd2};
			"/": return {1'b1, 4'd3};
			"%": return {1'b1, 4'd4};
			"=": return {1'b1, 4'd5};
			"!": return {1'b1, 4'd6};
			"<": return {1'b1, 4'd7};
			">": return {1'b1, 4'd8};
			"&": return {1'b1, 4'd9};
			"|": return {1'b1, 4'd10};
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [7:0] op_second(input logic [3:0] i);
		case (i)
			4'd9:    return "&";
			4'd10:   return "|";
			default: return "=";
		endcase
	endfunction

	function automatic logic [6:0] op_single(input logic [3:0] i);
		case (i)
			4'd6, 4'd9, 4'd10: return K_ERROR;
			4'd7:              return 7'd55;
			4'd8:              return 7'd57;
			default:           return 7'd42 + {2'd0, i, 1'b0};
		endcase
	endfunction

	function automatic logic [6:0] op_pair(input logic [3:0] i);
		case (i)
			4'd6:    return 7'd54;
			4'd7:    return 7'd56;
			4'd8:    return 7'd58;
			4'd9:    return 7'd59;
			4'd10:   return 7'd60;
			default: return 7'd43 + {2'd0, i, 1'b0};
		endcase
	endfunction

	// punctuation: hit flag and offset from K_PUNCT0
	function automatic logic [3:0] punct_find(input logic [7:0] c);
		case (c)
			",": return 4'b1000;
			";": return 4'b1001;
			"(": return 4'b1010;
			")": return 4'b1011;
			"[": return 4'b1100;
			"]": return 4'b1101;
			"{": return 4'b1110;
			"}": return 4'b1111;
			default: return 4'b0000;
		endcase
	endfunction

	// exact length and text match against all keywords in parallel
	function automatic logic [6:0] kw_kind(input word_t w, input logic [7:0] len);
		logic [6:0] kind;
		logic       m;
		kind = K_IDENT;
		for (int i = 0; i < 32; i++) begin
			m = (len == 8'(KW_LEN[i]));
			for (int k = 0; k < KW_MAX_LEN; k++) begin
				if (k < KW_LEN[i] && w[k] != KW_TEXT[i][8*(KW_LEN[i]-1-k) +: 8])
					m = 1'b0;
			end
			if (m)
				kind = 7'(i + 1);
		end
		return kind;
	endfunction

endpackage
`default_nettype wire

### src/csl_scan.sv
// Lexer state registers and the per-byte next-state / token logic.
// Depends on csl_pkg.
`default_nettype none
module csl_scan import csl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] c,
	input  wire logic       eof,
	output push_t           push
);

	mode_t       mode_q, mode_d;
	logic [15:0] line_q, line_d;
	logic [7:0]  len_q, len_d;
	logic        float_q, float_d, hex_q, hex_d;
	logic [3:0]  op_q, op_d;
	word_t       wbuf_q;
	logic        wr_en;
	logic [WIDX_W-1:0] wr_idx;

	logic        ea, eb, reproc, line_inc;
	logic [6:0]  ka, kb;
	logic [7:0]  la, lb, lg;
	logic [4:0]  of;
	logic [3:0]  pf;
	logic        chr_ok;

	always_comb begin
		mode_d = mode_q; line_d = line_q; len_d = len_q;
		float_d = float_q; hex_d = hex_q; op_d = op_q;
		wr_en = 1'b0; wr_idx = len_q[WIDX_W-1:0];
		ea = 1'b0; eb = 1'b0; ka = K_ERROR; kb = K_ERROR; la = len_q; lb = 8'd1;
		reproc = 1'b0; line_inc = 1'b0;
		lg = sat_inc8(len_q);
		of = op_find(c);
		pf = punct_find(c);
		chr_ok = (lg == 8'd3) || (lg == 8'd4 && mode_q == M_CHRB);

		if (eof) begin
			unique case (mode_q)
				M_IDENT: begin ea = 1'b1; ka = kw_kind(wbuf_q, len_q); end
				M_NUM, M_EXP: begin ea = 1'b1; ka = float_q ? K_DOUBLE : K_INT; end
				M_SUF_U: begin ea = 1'b1; ka = K_UINT; end
				M_SUF_L: begin ea = 1'b1; ka = float_q ? K_LDOUBLE : K_LONG; end
				M_OP: begin ea = 1'b1; ka = op_single(op_q); la = 8'd1; end
				M_CHR0, M_CHRB, M_CHRO, M_STR: begin ea = 1'b1; ka = K_ERROR; end
				default: ;
			endcase
			eb = 1'b1; kb = K_END; lb = 8'd0;
			mode_d = M_IDLE; line_d = 16'd1; len_d = 8'd0; float_d = 1'b0; hex_d = 1'b0;
		end else begin
			unique case (mode_q)
				M_IDENT: begin
					if (is_letter(c) || is_digit(c)) begin
						wr_en = (len_q < 8'(KW_MAX_LEN));
						len_d = lg;
					end else begin
						ea = 1'b1; ka = kw_kind(wbuf_q, len_q); reproc = 1'b1;
					end
				end
				M_NUM, M_EXP: begin
					if (mode_q == M_EXP && (c == "+" || c == "-")) begin
						mode_d = M_NUM; len_d = lg;
					end else if (is_digit(c) || c == ".") begin
						mode_d = M_NUM; len_d = lg;
						if (c == ".") float_d = 1'b1;
					end else if (c == "x" || c == "X") begin
						mode_d = M_NUM; len_d = lg; hex_d = 1'b1;
					end else if (hex_q && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
					begin
						mode_d = M_NUM; len_d = lg;
					end else if (!hex_q && (c == "e" || c == "E")) begin
						mode_d = M_EXP; len_d = lg; float_d = 1'b1;
					end else if (c == "u" || c == "U") begin
						if (float_q) begin
							ea = 1'b1; ka = K_ERROR; mode_d = M_IDLE;
						end else begin
							mode_d = M_SUF_U;
						end
					end else if (c == "l" || c == "L") begin
						mode_d = M_SUF_L;
					end else if (c == "f" || c == "F") begin
						ea = 1'b1; ka = K_FLOAT; mode_d = M_IDLE;
					end else begin
						ea = 1'b1; ka = float_q ? K_DOUBLE : K_INT; reproc = 1'b1;
					end
				end
				M_SUF_U: begin
					ea = 1'b1;
					if (c == "l" || c == "L") begin
						ka = K_ULONG; mode_d = M_IDLE;
					end else begin
						ka = K_UINT; reproc = 1'b1;
					end
				end
				M_SUF_L: begin
					ea = 1'b1;
					if (c == "u" || c == "U") begin
						ka = float_q ? K_ERROR : K_ULONG; mode_d = M_IDLE;
					end else begin
						ka = float_q ? K_LDOUBLE : K_LONG; reproc = 1'b1;
					end
				end
				M_OP: begin
					ea = 1'b1;
					if (c == op_second(op_q)) begin
						ka = op_pair(op_q); la = 8'd2; mode_d = M_IDLE;
					end else begin
						ka = op_single(op_q); la = 8'd1; reproc = 1'b1;
					end
				end
				M_CHR0, M_CHRB, M_CHRO: begin
					len_d = lg;
					if (c == "'") begin
						ea = 1'b1; ka = chr_ok ? K_CHAR : K_ERROR; la = lg; mode_d = M_IDLE;
					end else if (mode_q == M_CHR0) begin
						mode_d = (c == "\\") ? M_CHRB : M_CHRO;
					end
				end
				M_STR: begin
					len_d = lg;
					if (c == "\n") line_inc = 1'b1;
					if (c == "\"") begin
						ea = 1'b1; ka = K_STRING; la = lg; mode_d = M_IDLE;
					end
				end
				default: reproc = 1'b1;
			endcase

			// byte that ended a token starts the next one
			if (reproc) begin
				mode_d = M_IDLE; len_d = 8'd0;
				if (c == " " || c == "\t") begin
				end else if (c == "\n") begin
					line_inc = 1'b1;
				end else if (is_letter(c)) begin
					mode_d = M_IDENT; len_d = 8'd1; wr_en = 1'b1; wr_idx = '0;
				end else if (is_digit(c) || c == ".") begin
					mode_d = M_NUM; len_d = 8'd1; float_d = (c == "."); hex_d = 1'b0;
				end else if (of[4]) begin
					mode_d = M_OP; len_d = 8'd1; op_d = of[3:0];
				end else if (pf[3]) begin
					eb = 1'b1; kb = K_PUNCT0 + {4'd0, pf[2:0]};
				end else if (c == "#") begin
					eb = 1'b1; kb = K_ERROR; lb = 8'd2;
				end else if (c == "'") begin
					mode_d = M_CHR0; len_d = 8'd1;
				end else if (c == "\"") begin
					mode_d = M_STR; len_d = 8'd1;
				end else begin
					eb = 1'b1; kb = K_ERROR;
				end
			end
			if (line_inc && line_q != 16'hFFFF)
				line_d = line_q + 16'd1;
		end
	end

	// pack the beats in order; the final one carries last
	always_comb begin
		push.push0   = go && (ea || eb);
		push.push1   = go && ea && eb;
		push.r0.kind = ea ? ka : kb;
		push.r0.len  = ea ? la : lb;
		push.r0.line = line_q;
		push.r0.last = !(ea && eb);
		push.r1.kind = kb;
		push.r1.len  = lb;
		push.r1.line = line_q;
		push.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			line_q  <= 16'd1;
			len_q   <= 8'd0;
			float_q <= 1'b0;
			hex_q   <= 1'b0;
			op_q    <= 4'd0;
		end else if (go) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			len_q   <= len_d;
			float_q <= float_d;
			hex_q   <= hex_d;
			op_q    <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && wr_en)
			wbuf_q[wr_idx] <= c;
	end

endmodule
`default_nettype wire

### src/csl_resq.sv
// Four-entry result queue; takes up to two beats per cycle, hands out one per cycle unless stalled.
// Depends on csl_pkg.
`default_nettype none
module csl_resq import csl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push,
	output logic      room2,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      head
);

	res_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] npush;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != 3'd0);
	assign head      = mem_q[rp_q];
	assign npush     = {2'd0, push.push0} + {2'd0, push.push1};
	// two free slots after this cycle's pop
	assign room2     = (cnt_q - {2'd0, pop}) <= 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + npush[1:0];
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + npush - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.push0)
			mem_q[wp_q] <= push.r0;
		if (push.push1)
			mem_q[wp_q + 2'd1] <= push.r1;
	end

endmodule
`default_nettype wire

### src/c_subset_lexer.sv
// Top level of the C subset lexer: input register, scanner, result queue.
// Depends on csl_pkg, csl_scan, csl_resq.
`default_nettype none
// C subset lexer. One source byte per beat (char_code, or end_of_input to close the
// file) goes into an input register; the scanner consumes it and emits
// zero, one or two token beats (kind, line, length, last) into a four-entry result
// queue. Throughput is one input byte per cycle while the output side keeps up; a byte
// that ends one token and is itself a one-character token yields two beats, and the
// single-beat-per-cycle output port then sets the pace. The input register waits when
// the queue has fewer than two free slots. End of input flushes any open token, emits
// the end token, and returns line numbering to 1. No clearing pass after reset.
module c_subset_lexer import csl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       tok_class,
	output logic [15:0]      line_number,
	output logic [7:0]       token_length,
	output logic             last
);

	logic       v_s1;
	logic [7:0] c_s1;
	logic       eof_s1;
	logic       room2, go;
	push_t      push;
	res_t       head;

	// the held byte moves on whenever the queue can take both possible beats
	assign go       = v_s1 && room2;
	assign in_stall = v_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (!in_stall)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			c_s1   <= char_code;
			eof_s1 <= end_of_input;
		end
	end

	csl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.c      (c_s1),
		.eof    (eof_s1),
		.push   (push)
	);

	csl_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign tok_class    = head.kind;
	assign line_number  = head.line;
	assign token_length = head.len;
	assign last         = head.last;

endmodule
`default_nettype wire

### src/csl_checker.sv
// Port-level checks for the C subset lexer, bound to the top level.
// Depends on c_subset_lexer ports only.
`default_nettype none
module csl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [6:0]  tok_class,
	input wire logic [15:0] line_number,
	input wire logic [7:0]  token_length,
	input wire logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tok_class <= 7'd70)
		else $error("token kind out of range");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tok_class == 7'd70 |-> last && token_length == 8'd0)
		else $error("end token malformed");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 16'd0)
		else $error("line number zero");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.tok_class    (tok_class),
	.line_number  (line_number),
	.token_length (token_length),
	.last         (last)
);
`default_nettype wire
